// ===== rtl/rbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Rate-based pointer acceleration package
// Shared widths, constants, register indexes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rbpa_pkg;

    localparam int NUM_AXES_DEFAULT = 2;
    localparam int MAX_AXES         = 2;

    localparam int TYPE_W         = 8;
    localparam int CODE_W         = 16;
    localparam int VALUE_W        = 16;
    localparam int TIME_W         = 32;
    localparam int DIVISOR_W      = 32;
    localparam int AXES_IN_USE_W  = 2;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;

    // Gap window and speed arithmetic.
    localparam int MAX_GAP_MS      = 500;
    localparam int GAP_W           = 9;
    localparam int SPEED_NUM       = 1000;
    localparam int SPEED_W         = 10;
    localparam int DEFAULT_DIVISOR = 100;

    // The shared divider works on a 20-bit dividend (speed squared fits).
    localparam int DIV_W      = 2 * SPEED_W;
    localparam int DIV_STEPS  = DIV_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int SCALE_W    = DIV_W + 2;
    localparam int PROD_W     = VALUE_W + SCALE_W;

    localparam int CLAMP_HI = 127;
    localparam int CLAMP_LO = -127;

    // Reset values of the configuration registers.
    localparam logic [TYPE_W-1:0]        RST_EVENT_TYPE  = TYPE_W'(2);
    localparam logic [CODE_W-1:0]        RST_AXIS_FIRST  = CODE_W'(0);
    localparam logic [CODE_W-1:0]        RST_AXIS_SECOND = CODE_W'(1);
    localparam logic [AXES_IN_USE_W-1:0] RST_AXES_IN_USE = AXES_IN_USE_W'(2);
    localparam logic [DIVISOR_W-1:0]     RST_DIVISOR     = DIVISOR_W'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EVENT_TYPE_MATCH = 3'd0,
        CFG_AXIS_CODE_FIRST  = 3'd1,
        CFG_AXIS_CODE_SECOND = 3'd2,
        CFG_AXES_IN_USE      = 3'd3,
        CFG_ACCEL_DIVISOR    = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CHECK,
        ST_DIV_SPEED,
        ST_SQUARE,
        ST_DIV_SCALE,
        ST_MUL,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load_in;
        logic eval;
        logic div_start;
        logic div_step;
        logic square;
        logic mul;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic accel_ok;
        logic div_last;
    } dp_status_t;

endpackage

// ===== rtl/rbpa_if.sv =====
// ----------------------------------------------------------------------------
// Rate-based pointer acceleration channels
// Event input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface rbpa_event_if;
    import rbpa_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [TYPE_W-1:0]         event_type;
    logic [CODE_W-1:0]         event_code;
    logic signed [VALUE_W-1:0] event_value;
    logic [TIME_W-1:0]         time_ms;

    modport source (output valid, event_type, event_code, event_value, time_ms,
                    input ready);
    modport sink   (input valid, event_type, event_code, event_value, time_ms,
                    output ready);
endinterface

interface rbpa_result_if;
    import rbpa_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] out_value;
    logic                      was_accelerated;

    modport source (output valid, out_value, was_accelerated, input ready);
    modport sink   (input valid, out_value, was_accelerated, output ready);
endinterface

interface rbpa_cfg_if;
    import rbpa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== rtl/rbpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Rate-based pointer acceleration controller
// Sequences one item through evaluation and the check, then, when it is
// accelerated, two divisions, the square and the multiply, and the output register.
// ----------------------------------------------------------------------------
module rbpa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  rbpa_pkg::dp_status_t status,
    output rbpa_pkg::dp_cmd_t    cmd
);
    import rbpa_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = status.accel_ok ? ST_DIV_SPEED : ST_DONE;
            end
            ST_DIV_SPEED:
            begin
                if (status.div_last)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                state_next = ST_DIV_SCALE;
            end
            ST_DIV_SCALE:
            begin
                if (status.div_last)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_in  = in_valid;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            ST_CHECK:
            begin
                cmd.div_start = status.accel_ok;
            end
            ST_DIV_SPEED,
            ST_DIV_SCALE:
            begin
                cmd.div_step = 1'b1;
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/rbpa_datapath.sv =====
// ----------------------------------------------------------------------------
// Rate-based pointer acceleration datapath
// Configuration registers, per-axis timestamps, axis matching, a shared
// restoring divider, the scale multiply and the saturating output register.
// ----------------------------------------------------------------------------
module rbpa_datapath #(
    parameter int NUM_AXES = rbpa_pkg::NUM_AXES_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rbpa_pkg::dp_cmd_t                  cmd,
    output rbpa_pkg::dp_status_t               status,
    input  logic                               cfg_we,
    input  logic [rbpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rbpa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [rbpa_pkg::TYPE_W-1:0]        event_type,
    input  logic [rbpa_pkg::CODE_W-1:0]        event_code,
    input  logic signed [rbpa_pkg::VALUE_W-1:0] event_value,
    input  logic [rbpa_pkg::TIME_W-1:0]        time_ms,
    output logic signed [rbpa_pkg::VALUE_W-1:0] out_value,
    output logic                               was_accelerated
);
    import rbpa_pkg::*;

    localparam logic signed [PROD_W-1:0] PROD_HI = PROD_W'(CLAMP_HI);
    localparam logic signed [PROD_W-1:0] PROD_LO = PROD_W'(CLAMP_LO);

    // Configuration and per-axis state.
    logic [TYPE_W-1:0]        type_match_reg;
    logic [CODE_W-1:0]        axis_first_reg;
    logic [CODE_W-1:0]        axis_second_reg;
    logic [AXES_IN_USE_W-1:0] axes_in_use_reg;
    logic [DIVISOR_W-1:0]     divisor_reg;
    logic [TIME_W-1:0]        stamp_reg [NUM_AXES];

    // Latched item.
    logic [TYPE_W-1:0]         type_reg;
    logic [CODE_W-1:0]         code_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [TIME_W-1:0]         time_reg;

    logic                      accel_reg;
    logic [GAP_W-1:0]          gap_reg;

    // Divider registers; the quotient shifts into the dividend register.
    logic [DIV_W-1:0]          dvd_reg;
    logic [DIVISOR_W-1:0]      dvs_reg;
    logic [DIVISOR_W-1:0]      rem_reg;
    logic [DIV_CNT_W-1:0]      cnt_reg;
    logic [DIV_W-1:0]          dvd_next;
    logic [DIVISOR_W-1:0]      rem_next;
    logic [DIVISOR_W:0]        rem_shift;
    logic                      q_bit;

    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic                      out_accel_reg;

    // Matching.
    logic [NUM_AXES-1:0]       axis_hit;
    logic [NUM_AXES-1:0]       axis_sel;
    logic [TIME_W-1:0]         gap_sel;
    logic                      type_ok;
    logic                      accel_next;
    logic [DIVISOR_W-1:0]      div_eff;
    logic [SPEED_W-1:0]        speed;
    logic [DIV_W:0]            scale;
    logic signed [SCALE_W-1:0] scale_s;
    logic signed [VALUE_W-1:0] clamped;

    assign type_ok = (type_reg == type_match_reg);

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            axis_hit[i] = (((i == 0) ? axis_first_reg : axis_second_reg) == code_reg)
                          && (AXES_IN_USE_W'(i) < axes_in_use_reg) && type_ok;
        end
    end

    // The lowest matching axis wins.
    always_comb
    begin
        logic seen;
        seen     = 1'b0;
        axis_sel = '0;
        gap_sel  = '0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            axis_sel[i] = axis_hit[i] && !seen;
            seen        = seen || axis_hit[i];
            if (axis_sel[i])
            begin
                gap_sel = time_reg - stamp_reg[i];
            end
        end
    end

    assign accel_next = (|axis_sel) && (gap_sel != '0) && (gap_sel <= TIME_W'(MAX_GAP_MS));
    assign div_eff    = (divisor_reg == '0) ? DIVISOR_W'(DEFAULT_DIVISOR) : divisor_reg;

    // One restoring divider step.
    assign rem_shift = {rem_reg, dvd_reg[DIV_W-1]};
    assign q_bit     = (rem_shift >= {1'b0, dvs_reg});
    assign rem_next  = q_bit ? DIVISOR_W'(rem_shift - {1'b0, dvs_reg})
                             : rem_shift[DIVISOR_W-1:0];
    assign dvd_next  = {dvd_reg[DIV_W-2:0], q_bit};

    assign status.div_last = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign status.accel_ok = accel_reg;

    assign speed   = dvd_reg[SPEED_W-1:0];
    assign scale   = {1'b0, dvd_reg} + (DIV_W + 1)'(1);
    assign scale_s = $signed({1'b0, scale});

    always_comb
    begin
        priority if (prod_reg > PROD_HI)
        begin
            clamped = VALUE_W'(CLAMP_HI);
        end
        else if (prod_reg < PROD_LO)
        begin
            clamped = VALUE_W'(CLAMP_LO);
        end
        else
        begin
            clamped = prod_reg[VALUE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_match_reg  <= RST_EVENT_TYPE;
            axis_first_reg  <= RST_AXIS_FIRST;
            axis_second_reg <= RST_AXIS_SECOND;
            axes_in_use_reg <= RST_AXES_IN_USE;
            divisor_reg     <= RST_DIVISOR;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                stamp_reg[i] <= '0;
            end
            cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_EVENT_TYPE_MATCH: type_match_reg  <= cfg_wdata[TYPE_W-1:0];
                    CFG_AXIS_CODE_FIRST:  axis_first_reg  <= cfg_wdata[CODE_W-1:0];
                    CFG_AXIS_CODE_SECOND: axis_second_reg <= cfg_wdata[CODE_W-1:0];
                    CFG_AXES_IN_USE:      axes_in_use_reg <= cfg_wdata[AXES_IN_USE_W-1:0];
                    CFG_ACCEL_DIVISOR:    divisor_reg     <= cfg_wdata[DIVISOR_W-1:0];
                    default:              ;
                endcase
            end
            if (cmd.eval)
            begin
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    if (axis_sel[i])
                    begin
                        stamp_reg[i] <= time_reg;
                    end
                end
            end
            if (cmd.div_start || cmd.square)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            type_reg  <= event_type;
            code_reg  <= event_code;
            value_reg <= event_value;
            time_reg  <= time_ms;
        end
        if (cmd.eval)
        begin
            accel_reg <= accel_next;
            gap_reg   <= gap_sel[GAP_W-1:0];
        end
        if (cmd.div_start)
        begin
            dvd_reg <= DIV_W'(SPEED_NUM);
            dvs_reg <= DIVISOR_W'(gap_reg);
            rem_reg <= '0;
        end
        else if (cmd.square)
        begin
            dvd_reg <= speed * speed;
            dvs_reg <= div_eff;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
        if (cmd.mul)
        begin
            prod_reg <= value_reg * scale_s;
        end
        if (cmd.load_out)
        begin
            out_value_reg <= accel_reg ? clamped : value_reg;
            out_accel_reg <= accel_reg;
        end
    end

    assign out_value       = out_value_reg;
    assign was_accelerated = out_accel_reg;

endmodule

// ===== rtl/rate_based_pointer_accel_core.sv =====
// ----------------------------------------------------------------------------
// Rate-based pointer acceleration core
// Matches pointer events to tracked axes and scales fast movements by a
// quadratic speed curve with saturation.
// ----------------------------------------------------------------------------
// An accelerated item passes evaluation, the check, the shared 20-step
// restoring divider for speed, the square, the divider for the scale, the
// multiply and the result register; a passed-through item goes from the
// check to the result register. No new item is taken before the current one
// is loaded there, but one is let in while the previous result waits. Reset
// clears the configuration to its defaults and all stored axis times to zero.
module rate_based_pointer_accel_core #(
    parameter int NUM_AXES = rbpa_pkg::NUM_AXES_DEFAULT
) (
    input logic           clk,
    input logic           rst_n,
    rbpa_event_if.sink    evt,
    rbpa_result_if.source res,
    rbpa_cfg_if.sink      cfg
);
    import rbpa_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg.ready = 1'b1;

    rbpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (evt.valid),
        .in_ready  (evt.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rbpa_datapath #(
        .NUM_AXES (NUM_AXES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_wdata       (cfg.wdata),
        .event_type      (evt.event_type),
        .event_code      (evt.event_code),
        .event_value     (evt.event_value),
        .time_ms         (evt.time_ms),
        .out_value       (res.out_value),
        .was_accelerated (res.was_accelerated)
    );

endmodule
